// ----- hw/rtl/decimal_number_glyph_renderer_defines.svh -----
// Assertion macros used by the checker file of the glyph renderer.
`ifndef DECIMAL_NUMBER_GLYPH_RENDERER_DEFINES_SVH
`define DECIMAL_NUMBER_GLYPH_RENDERER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DNGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DNGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dngr_pkg.sv -----
// Types, constants and font ROM of the decimal glyph renderer.
package dngr_pkg;

    localparam int GLYPH_WIDTH  = 3;
    localparam int GLYPH_ROWS   = 5;
    localparam int MAX_DIGITS   = 5;
    localparam int CHAR_SPACING = 1;
    localparam int ADV_MUL      = GLYPH_WIDTH + CHAR_SPACING;

    // floor(n / 10) == (n * 52429) >> 19 for every 16-bit n
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [2:0] ROW_LAST  = 3'(GLYPH_ROWS - 1);
    localparam logic [2:0] STEP_LAST = 3'(MAX_DIGITS - 1);

    typedef logic [2:0] t_glyph_row;

    localparam t_glyph_row FONT_ROM [10][GLYPH_ROWS] = '{
        '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7},
        '{3'd2, 3'd6, 3'd2, 3'd2, 3'd7},
        '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
        '{3'd7, 3'd1, 3'd7, 3'd1, 3'd7},
        '{3'd5, 3'd5, 3'd7, 3'd1, 3'd1},
        '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
        '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7},
        '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1},
        '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7},
        '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7}
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_last;
        logic row_last;
        logic out_free;
    } t_dp_status;

    function automatic t_glyph_row font_row(input logic [3:0] digit, input logic [2:0] row);
        t_glyph_row res;
        res = '0;
        if (digit <= 4'd9 && row <= ROW_LAST) begin
            res = FONT_ROM[digit][row];
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/dngr_if.sv -----
// Valid/ready word channels: number request in, glyph row out.
interface dngr_in_if;
    import dngr_pkg::*;
    logic        valid;
    logic        ready;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [15:0] value;
    logic [7:0]  scale;
    logic        color;

    modport source (output valid, x_pos, y_pos, value, scale, color, input ready);
    modport sink   (input valid, x_pos, y_pos, value, scale, color, output ready);
endinterface

interface dngr_out_if;
    import dngr_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] row_x;
    logic [7:0] row_y;
    t_glyph_row row_bits;
    logic [7:0] block_size;
    logic       pixel_color;
    logic       last;

    modport source (output valid, row_x, row_y, row_bits, block_size, pixel_color, last,
                    input ready);
    modport sink   (input valid, row_x, row_y, row_bits, block_size, pixel_color, last,
                    output ready);
endinterface

// ----- hw/rtl/dngr_datapath.sv -----
// Datapath: digit extraction, cursor/row counters and output word register.
module dngr_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dngr_pkg::t_dp_cmd    i_cmd,
    output dngr_pkg::t_dp_status o_status,
    input  logic [7:0]           i_x_pos,
    input  logic [7:0]           i_y_pos,
    input  logic [15:0]          i_value,
    input  logic [7:0]           i_scale,
    input  logic                 i_color,
    dngr_out_if.source           o_out
);
    import dngr_pkg::*;

    logic [7:0]  r_x, r_y, r_sc, r_adv, r_row_y;
    logic [15:0] r_num;
    logic        r_color;
    logic [3:0]  r_digits [MAX_DIGITS];
    logic [2:0]  r_step, r_top, r_dig, r_row;

    logic [7:0]  r_o_x, r_o_y, r_o_sc;
    t_glyph_row  r_o_bits;
    logic        r_o_color, r_o_last, r_out_valid;

    logic [31:0] prod;
    logic [12:0] quo;
    logic [15:0] rem;
    logic [3:0]  digit;
    logic [7:0]  sc_eff;
    logic [10:0] adv_full;
    logic        row_last;

    // divide by ten through the reciprocal, remainder by shift-add
    always_comb begin
        prod     = 32'(r_num) * 32'(DIV10_RECIP);
        quo      = prod[DIV10_SHIFT +: 13];
        rem      = r_num - 16'({quo, 3'b000}) - 16'({quo, 1'b0});
        digit    = rem[3:0];
        sc_eff   = (i_scale == 8'd0) ? 8'd1 : i_scale;
        adv_full = 11'(ADV_MUL) * {3'b000, sc_eff};
        row_last = (r_dig == 3'd0) && (r_row == ROW_LAST);
    end

    assign o_status.conv_last = (r_step == STEP_LAST);
    assign o_status.row_last  = row_last;
    assign o_status.out_free  = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= i_x_pos;
            r_y     <= i_y_pos;
            r_num   <= i_value;
            r_sc    <= sc_eff;
            r_color <= i_color;
            r_adv   <= adv_full[7:0];
            r_step  <= 3'd0;
            r_top   <= 3'd0;
        end
        if (i_cmd.conv) begin
            r_digits[r_step] <= digit;
            r_num            <= {3'b000, quo};
            r_step           <= r_step + 3'd1;
            if (digit != 4'd0) begin
                r_top <= r_step;
            end
            // most significant nonzero digit starts the emit pass
            r_dig   <= (digit != 4'd0) ? r_step : r_top;
            r_row   <= 3'd0;
            r_row_y <= r_y;
        end
        if (i_cmd.emit) begin
            r_o_x     <= r_x;
            r_o_y     <= r_row_y;
            r_o_bits  <= font_row(r_digits[r_dig], r_row);
            r_o_sc    <= r_sc;
            r_o_color <= r_color;
            r_o_last  <= row_last;
            if (r_row == ROW_LAST) begin
                r_row   <= 3'd0;
                r_dig   <= r_dig - 3'd1;
                r_x     <= r_x + r_adv;
                r_row_y <= r_y;
            end else begin
                r_row   <= r_row + 3'd1;
                r_row_y <= r_row_y + r_sc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.row_x       = r_o_x;
    assign o_out.row_y       = r_o_y;
    assign o_out.row_bits    = r_o_bits;
    assign o_out.block_size  = r_o_sc;
    assign o_out.pixel_color = r_o_color;
    assign o_out.last        = r_o_last;

endmodule

// ----- hw/rtl/dngr_ctrl.sv -----
// Controller: sequences load, digit conversion and row emission.
module dngr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dngr_pkg::t_dp_status i_status,
    output dngr_pkg::t_dp_cmd    o_cmd
);
    import dngr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (i_status.conv_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.row_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CONV: begin
                o_cmd.conv = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- hw/rtl/decimal_number_glyph_renderer.sv -----
// Decimal glyph renderer: 16-bit value to 3x5 font rows, one row word per cycle
//   while the output is not stalled. The input word is taken, the divide-by-ten
//   digit extraction runs, then the first row word enters the output register.
// A new number is taken only after the last row word of the previous one is
//   emitted, paced by digit extraction and the single row output register.
// Reset (synchronous, active low) returns the controller to idle and empties
//   the output register; data registers are not reset.
module decimal_number_glyph_renderer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dngr_in_if.sink   i_in,
    dngr_out_if.source o_out
);
    import dngr_pkg::*;

    // controller and datapath talk only through these two groups
    t_dp_cmd    cmd;
    t_dp_status status;

    // input ready comes from the controller; payload is latched on cmd.load
    dngr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath owns the digit store, cursor, row counter and the output word
    dngr_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_x_pos  (i_in.x_pos),
        .i_y_pos  (i_in.y_pos),
        .i_value  (i_in.value),
        .i_scale  (i_in.scale),
        .i_color  (i_in.color),
        .o_out    (o_out)
    );

endmodule

// ----- hw/rtl/dngr_checker.sv -----
// Port-level checker for the glyph renderer, bound to the top level.
`include "decimal_number_glyph_renderer_defines.svh"

module dngr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_row_x,
    input logic [7:0] i_row_y,
    input logic [7:0] i_block_size,
    input logic       i_last
);

    // stalled output word must hold
    `DNGR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_row_x) && $stable(i_row_y) && $stable(i_last), "output word changed while stalled")

    // input is closed during digit conversion, so no back-to-back accept
    `DNGR_ASSERT_NXT(a_no_b2b, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input taken twice in a row")

    // while a non-final row is pending, more rows follow: input stays closed
    `DNGR_ASSERT_IMP(a_busy_mid, i_clk, i_rst_n, i_out_valid && !i_last, !i_in_ready, "input open mid-number")

    // effective scale is never zero
    `DNGR_ASSERT_IMP(a_block_nz, i_clk, i_rst_n, i_out_valid, i_block_size != 8'd0, "zero block size")

endmodule

bind decimal_number_glyph_renderer dngr_checker u_dngr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_row_x      (o_out.row_x),
    .i_row_y      (o_out.row_y),
    .i_block_size (o_out.block_size),
    .i_last       (o_out.last)
);
